// ===== hw/rtl/itoa_pkg.sv =====
// Shared types, constants and helper functions for the integer to ASCII formatter.
// No dependencies; every other file of the block imports this package.
package itoa_pkg;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int CHAR_W   = 8;
	localparam int DIGITS   = 10;
	localparam int NIBBLE_W = 4;
	localparam int BCD_W    = DIGITS * NIBBLE_W;
	localparam int DCNT_W   = $clog2(DIGITS + 1);
	localparam int SCNT_W   = $clog2(VALUE_W);

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [CHAR_W-1:0]   char_t;
	typedef logic [NIBBLE_W-1:0] nibble_t;
	typedef logic [BCD_W-1:0]    bcd_t;
	typedef logic [DCNT_W-1:0]   dcnt_t;
	typedef logic [SCNT_W-1:0]   scnt_t;

	// Request modes.
	localparam op_t OP_RAW  = 2'd0;
	localparam op_t OP_UDEC = 2'd1;
	localparam op_t OP_SDEC = 2'd2;
	localparam op_t OP_HEX  = 2'd3;

	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_MINUS = 8'h2d;
	localparam char_t CHAR_LOW_A = 8'h61;
	localparam nibble_t NIB_TEN  = 4'd10;

	// Handshake between the sequencer and the conversion unit.
	typedef struct packed {
		logic   start;
		value_t magnitude;
	} dab_req_t;

	typedef struct packed {
		logic done;
		bcd_t digits;
	} dab_rsp_t;

	// Lower-case hex character for one nibble.
	function automatic char_t hex_char(input nibble_t nib);
		char_t base;
		base = (nib < NIB_TEN) ? CHAR_ZERO : (CHAR_LOW_A - char_t'(NIB_TEN));
		return base + {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
	endfunction

	// Decimal character for one BCD digit.
	function automatic char_t dec_char(input nibble_t nib);
		return CHAR_ZERO + {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
	endfunction

endpackage

// ===== hw/rtl/itoa_req_if.sv =====
// Request channel: valid/ready handshake carrying a mode and a 32-bit operand.
// Depends on itoa_pkg for the payload types.
interface itoa_req_if;
	import itoa_pkg::*;

	logic   valid;
	logic   ready;
	op_t    operation;
	value_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);

endinterface

// ===== hw/rtl/itoa_char_if.sv =====
// Character channel: valid/ready handshake carrying one ASCII character and a last flag.
// Depends on itoa_pkg for the payload types.
interface itoa_char_if;
	import itoa_pkg::*;

	logic  valid;
	logic  ready;
	char_t character;
	logic  last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);

endinterface

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter, top level: sequencer, character register, BCD unit.
// Raw and hex requests go straight to emitting; decimal requests first pass the 32-step
// BCD conversion unit and its done handoff, skip leading zeros, then send the digits, a
// sign adding a leading minus. A new request is taken only after the last character of
// the previous one is loaded. One character leaves per cycle unless the receiver stalls.
// Reset (arst_n, asynchronous, active low) empties the sequencer and the output register.
module integer_to_ascii_formatter (
	input  logic clk,
	input  logic arst_n,
	itoa_req_if.sink    request,
	itoa_char_if.source text
);
	import itoa_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_SKIP = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t   state_q;
	op_t      op_q;
	logic     sign_q;
	bcd_t     bcd_q;
	dcnt_t    cnt_q;
	logic     out_valid_q;
	char_t    out_char_q;
	logic     out_last_q;

	dab_req_t dab_req;
	dab_rsp_t dab_rsp;

	logic     accept;
	logic     negative;
	logic     load;
	nibble_t  top_nib;
	char_t    next_char;
	logic     next_last;

	// The block takes a new request only when the sequencer is idle; the output
	// register may still hold the final character of the previous request.
	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;

	// In signed mode a set top bit means a leading minus and a negated magnitude.
	assign negative = (request.operation == OP_SDEC) && request.value[VALUE_W-1];

	assign dab_req.start     = accept &&
	                           ((request.operation == OP_UDEC) || (request.operation == OP_SDEC));
	assign dab_req.magnitude = negative ? (~request.value + value_t'(1)) : request.value;

	itoa_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dab_req),
		.rsp    (dab_rsp)
	);

	// Every character but the minus sign is taken from the top of the digit register, which
	// shifts up by one nibble per emitted digit.
	assign top_nib = bcd_q[BCD_W-1 -: NIBBLE_W];

	// In the emit state the output register is loaded whenever it is empty or being drained.
	assign load = (state_q == S_EMIT) && (!out_valid_q || text.ready);

	always_comb begin
		next_last = 1'b0;
		if (sign_q) begin
			next_char = CHAR_MINUS;
		end else begin
			next_last = (cnt_q == dcnt_t'(1));
			case (op_q)
				OP_RAW:  next_char = bcd_q[BCD_W-1 -: CHAR_W];
				OP_HEX:  next_char = hex_char(top_nib);
				default: next_char = dec_char(top_nib);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sign_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new character replaces the one leaving; otherwise a drained register empties.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (text.valid && text.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sign_q <= negative;
						case (request.operation)
							OP_RAW: begin
								cnt_q   <= dcnt_t'(1);
								state_q <= S_EMIT;
							end
							OP_HEX: begin
								cnt_q   <= dcnt_t'(2);
								state_q <= S_EMIT;
							end
							default: begin
								cnt_q   <= dcnt_t'(DIGITS);
								state_q <= S_CONV;
							end
						endcase
					end
				end
				S_CONV: begin
					if (dab_rsp.done) begin
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					// Drop leading zeros, always keeping the last digit so zero prints as one '0'.
					if ((top_nib == '0) && (cnt_q != dcnt_t'(1))) begin
						cnt_q <= cnt_q - dcnt_t'(1);
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (sign_q) begin
							sign_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - dcnt_t'(1);
							if (cnt_q == dcnt_t'(1)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= request.operation;
			bcd_q <= {request.value[CHAR_W-1:0], {(BCD_W-CHAR_W){1'b0}}};
		end else if ((state_q == S_CONV) && dab_rsp.done) begin
			bcd_q <= dab_rsp.digits;
		end else if ((state_q == S_SKIP) && (top_nib == '0) && (cnt_q != dcnt_t'(1))) begin
			bcd_q <= {bcd_q[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
		end else if (load && !sign_q) begin
			bcd_q <= {bcd_q[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
		end
		if (load) begin
			out_char_q <= next_char;
			out_last_q <= next_last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

endmodule

// ===== hw/rtl/itoa_dabble.sv =====
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle, one step per operand bit.
// Depends on itoa_pkg for widths and the request/response structs.
module itoa_dabble (
	input  logic               clk,
	input  logic               arst_n,
	input  itoa_pkg::dab_req_t req,
	output itoa_pkg::dab_rsp_t rsp
);
	import itoa_pkg::*;

	value_t bin_q;
	bcd_t   bcd_q;
	scnt_t  cnt_q;
	logic   busy_q;
	logic   done_q;
	bcd_t   adj;

	// Each digit of five or more gets three added before the shift.
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*NIBBLE_W +: NIBBLE_W] >= nibble_t'(5)) begin
				adj[d*NIBBLE_W +: NIBBLE_W] = bcd_q[d*NIBBLE_W +: NIBBLE_W] + nibble_t'(3);
			end else begin
				adj[d*NIBBLE_W +: NIBBLE_W] = bcd_q[d*NIBBLE_W +: NIBBLE_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + scnt_t'(1);
				if (cnt_q == scnt_t'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			bin_q <= req.magnitude;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.digits = bcd_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_formatter: directed and random print requests,
// checked character by character. Depends on itoa_pkg, itoa_req_if, itoa_char_if and the RTL.
module testbench;
	import itoa_pkg::*;

	// One print request as it travels on the request channel.
	typedef struct packed {
		op_t    operation;
		value_t value;
	} print_request_t;

	// One character of formatted text as it leaves on the text channel.
	typedef struct packed {
		char_t character;
		logic  last;
	} text_beat_t;

	// Values that sit on the edges of the signed and unsigned ranges.
	localparam value_t CORNER_VALUES [4] = '{32'h0000_0000, 32'hffff_ffff,
		32'h8000_0000, 32'h7fff_ffff};

	// Random requests per phase, the length of the long receiver stall and the
	// number of accepted requests into the last phase at which it begins.
	localparam int RANDOM_PER_PHASE = 110;
	localparam int LONG_HOLD_OFF    = 300;
	localparam int HOLD_OFF_DELAY   = 20;

	// The limit must cover the slowest request, and every character may wait out a receiver
	// stall; 5 ms is many times what the run normally needs.
	localparam int RUN_LIMIT_NS = 5_000_000;

	logic clk = 1'b0;
	logic arst_n;

	itoa_req_if  request_bus ();
	itoa_char_if text_bus ();

	integer_to_ascii_formatter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_bus),
		.text    (text_bus)
	);

	// Requests that the driver has yet to put on the bus, and characters that the
	// block still owes for requests it has already taken, oldest first.
	print_request_t pending_requests [$];
	text_beat_t     expected_text [$];

	int accepted_count;
	int failure_count = 0;

	// Idle rates in percent; the stimulus process moves them between phases.
	int sender_idle_pct   = 19;
	int receiver_idle_pct = 63;

	// Long receiver stall: it starts once the accepted count reaches hold_off_at and
	// then runs down one per cycle in its own process.
	int   hold_off_at = -1;
	int   hold_off_left;
	logic hold_off_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Appends the decimal digits of a magnitude to the expected text, most significant
	// first. A zero magnitude still yields one '0' because the loop runs at least once.
	function automatic void push_decimal(input value_t magnitude);
		char_t  digit_chars [$];
		value_t rest;
		rest = magnitude;
		do begin
			digit_chars.push_front(CHAR_ZERO + char_t'(rest % 10));
			rest = rest / 10;
		end while (rest != 0);
		foreach (digit_chars[i]) begin
			expected_text.push_back('{character: digit_chars[i], last: 1'b0});
		end
	endfunction

	// Lower-case hex character of one nibble.
	function automatic char_t hex_digit(input nibble_t nib);
		if (nib < 4'd10) begin
			return CHAR_ZERO + char_t'(nib);
		end
		return char_t'("a") + char_t'(nib) - char_t'(10);
	endfunction

	// Works out the text that one accepted request must produce and queues it.
	function automatic void format_request(input op_t operation, input value_t value);
		case (operation)
			OP_RAW: begin
				// Only the low byte counts; any byte value passes through unchanged.
				expected_text.push_back('{character: value[7:0], last: 1'b0});
			end
			OP_UDEC: begin
				push_decimal(value);
			end
			OP_SDEC: begin
				// Negative values print a minus sign and then the magnitude. The
				// magnitude of the most negative value still fits in 32 unsigned bits.
				if (value[VALUE_W-1]) begin
					expected_text.push_back('{character: CHAR_MINUS, last: 1'b0});
					push_decimal(~value + value_t'(1));
				end else begin
					push_decimal(value);
				end
			end
			default: begin
				expected_text.push_back('{character: hex_digit(value[7:4]), last: 1'b0});
				expected_text.push_back('{character: hex_digit(value[3:0]), last: 1'b0});
			end
		endcase
		expected_text[$].last = 1'b1;
	endfunction

	// Random request. Half the values are small, corners or near a digit-count boundary, so that
	// every output length turns up often; the rest are fully random 32-bit words.
	function automatic print_request_t random_request();
		print_request_t req;
		value_t         power;
		req.operation = op_t'($urandom_range(3));
		case ($urandom_range(9))
			0: req.value = $urandom_range(9);
			1: req.value = $urandom_range(999);
			2: req.value = value_t'(0) - value_t'($urandom_range(1000, 1));
			3: req.value = CORNER_VALUES[$urandom_range(3)];
			4: begin
				power = 1;
				repeat ($urandom_range(9)) power = power * 10;
				req.value = power - value_t'($urandom_range(1));
			end
			default: req.value = $urandom;
		endcase
		return req;
	endfunction

	// Driver. The transaction on the bus is predicted at the edge that accepts it; a new
	// request goes out whenever the bus is free, unless the sender idles this cycle.
	always @(posedge clk or negedge arst_n) begin
		print_request_t next_req;
		if (!arst_n) begin
			request_bus.valid     <= 1'b0;
			request_bus.operation <= OP_RAW;
			request_bus.value     <= '0;
			accepted_count        <= 0;
		end else begin
			if (request_bus.valid && request_bus.ready) begin
				format_request(request_bus.operation, request_bus.value);
				accepted_count <= accepted_count + 1;
			end
			if (!request_bus.valid || request_bus.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_req = pending_requests.pop_front();
					request_bus.valid     <= 1'b1;
					request_bus.operation <= next_req.operation;
					request_bus.value     <= next_req.value;
				end else begin
					request_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver stall. The sender keeps offering requests meanwhile, so the block
	// fills up and has to hold its request ready low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_left <= 0;
			hold_off_done <= 1'b0;
		end else if (!hold_off_done && accepted_count == hold_off_at) begin
			hold_off_left <= LONG_HOLD_OFF;
			hold_off_done <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
		end
	end

	// Monitor. Every accepted character is compared with the oldest expected one;
	// ready is drawn again every cycle from the current idle rate.
	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			text_bus.ready <= 1'b0;
		end else begin
			if (text_bus.valid && text_bus.ready) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual character %h last %b",
						$time, text_bus.character, text_bus.last);
					failure_count++;
				end else begin
					want = expected_text.pop_front();
					if (text_bus.character !== want.character) begin
						$display("%0t: character mismatch, expected %h, actual %h",
							$time, want.character, text_bus.character);
						failure_count++;
					end
					if (text_bus.last !== want.last) begin
						$display("%0t: last mismatch, expected %b, actual %b",
							$time, want.last, text_bus.last);
						failure_count++;
					end
				end
			end
			text_bus.ready <= (hold_off_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Waits until the driver has nothing left to send and every expected character has
	// arrived. Checked at the falling edge, when all clocked updates have settled.
	task automatic wait_until_drained();
		do begin
			@(negedge clk);
		end while (pending_requests.size() != 0 || request_bus.valid || expected_text.size() != 0);
	endtask

	// Stimulus: directed cases, then three random phases with different idle patterns.
	// Between phases the sender pauses until the block has delivered everything.
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Raw bytes: zero, the top of the ASCII range and above it, and a word whose
		// upper bits must be ignored.
		pending_requests.push_back('{OP_RAW, 32'h0000_0000});
		pending_requests.push_back('{OP_RAW, 32'h0000_007f});
		pending_requests.push_back('{OP_RAW, 32'h0000_0080});
		pending_requests.push_back('{OP_RAW, 32'h0000_00ff});
		pending_requests.push_back('{OP_RAW, 32'hffff_ff41});
		// Unsigned decimal: zero, one and two digits, the longest numbers.
		pending_requests.push_back('{OP_UDEC, 32'd0});
		pending_requests.push_back('{OP_UDEC, 32'd9});
		pending_requests.push_back('{OP_UDEC, 32'd10});
		pending_requests.push_back('{OP_UDEC, 32'd999_999_999});
		pending_requests.push_back('{OP_UDEC, 32'd1_000_000_000});
		pending_requests.push_back('{OP_UDEC, 32'hffff_ffff});
		// Signed decimal: zero, the most negative value, minus one, the largest
		// positive value, a small negative and an ordinary positive number.
		pending_requests.push_back('{OP_SDEC, 32'd0});
		pending_requests.push_back('{OP_SDEC, 32'h8000_0000});
		pending_requests.push_back('{OP_SDEC, 32'hffff_ffff});
		pending_requests.push_back('{OP_SDEC, 32'h7fff_ffff});
		pending_requests.push_back('{OP_SDEC, 32'hffff_fff6});
		pending_requests.push_back('{OP_SDEC, 32'd12345});
		// Hex byte: both ends, digit and letter nibbles in each place, upper bits set.
		pending_requests.push_back('{OP_HEX, 32'h0000_0000});
		pending_requests.push_back('{OP_HEX, 32'h0000_00ff});
		pending_requests.push_back('{OP_HEX, 32'h0000_000a});
		pending_requests.push_back('{OP_HEX, 32'h0000_00a9});
		pending_requests.push_back('{OP_HEX, 32'hdead_be5f});
		wait_until_drained();

		// Random phase with a mostly busy sender and a hesitant receiver.
		repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
		wait_until_drained();

		// Same again with the roles swapped.
		sender_idle_pct   <= 63;
		receiver_idle_pct <= 19;
		repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
		wait_until_drained();

		// Full speed on both sides, with one long receiver stall partway through.
		sender_idle_pct   <= 0;
		receiver_idle_pct <= 0;
		hold_off_at       <= accepted_count + HOLD_OFF_DELAY;
		repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
		wait_until_drained();

		// A stray character would show up within a few conversion times.
		repeat (100) @(posedge clk);
		if (failure_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_req_if.sv
hw/rtl/itoa_char_if.sv
hw/rtl/itoa_dabble.sv
hw/rtl/integer_to_ascii_formatter.sv
test/testbench.sv
